FILE: hw/rtl/wts_pkg.sv
// Shared types, request and status codes, and Q16 weight table for the
// windowed Tanimoto similarity block. No dependencies.
`default_nettype none
package wts_pkg;

  localparam int unsigned KeyW  = 32;
  localparam int unsigned SimW  = 17;
  localparam int unsigned StatW = 2;
  localparam int unsigned WinW  = 3;
  localparam int unsigned ReqW  = 2;

  localparam logic [ReqW-1:0] REQ_LOAD_A  = 2'd0;
  localparam logic [ReqW-1:0] REQ_LOAD_B  = 2'd1;
  localparam logic [ReqW-1:0] REQ_COMPUTE = 2'd2;

  localparam logic [StatW-1:0] STAT_OK        = 2'd0;
  localparam logic [StatW-1:0] STAT_BOTH_EMPT = 2'd1;
  localparam logic [StatW-1:0] STAT_ONE_EMPT  = 2'd2;
  localparam logic [StatW-1:0] STAT_DROPPED   = 2'd3;

  localparam logic [WinW-1:0] MAX_WIN   = 3'd5;
  localparam logic [SimW-1:0] Q16_ONE   = 17'd65536;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_MRG_RD  = 10'b0000000010,
    S_MRG_CMP = 10'b0000000100,
    S_PA_RD   = 10'b0000001000,
    S_PA_WT   = 10'b0000010000,
    S_SCAN_B  = 10'b0000100000,
    S_SCAN_A  = 10'b0001000000,
    S_DIV_ST  = 10'b0010000000,
    S_DIV     = 10'b0100000000,
    S_DONE    = 10'b1000000000
  } state_e;

  function automatic logic [SimW-1:0] weight_q16(input logic [WinW-1:0] d);
    logic [SimW-1:0] w;
    case (d)
      3'd0:    w = 17'd65536;
      3'd1:    w = 17'd65130;
      3'd2:    w = 17'd64042;
      3'd3:    w = 17'd61158;
      3'd4:    w = 17'd55135;
      3'd5:    w = 17'd45318;
      default: w = 17'd0;
    endcase
    return w;
  endfunction

  function automatic logic [KeyW-1:0] abs_diff(input logic [KeyW-1:0] x,
                                               input logic [KeyW-1:0] y);
    return (x > y) ? (x - y) : (y - x);
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/wts_if.sv
// Valid/ready channel interfaces for requests, results and configuration.
// Depends on wts_pkg.
`default_nettype none
interface wts_req_if import wts_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ReqW-1:0] req_type;
  logic [KeyW-1:0] key;
  modport source (output valid, req_type, key, input ready);
  modport sink   (input valid, req_type, key, output ready);
endinterface

interface wts_res_if import wts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SimW-1:0]  similarity;
  logic [StatW-1:0] status;
  modport source (output valid, similarity, status, input ready);
  modport sink   (input valid, similarity, status, output ready);
endinterface

interface wts_cfg_if import wts_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [WinW-1:0] window_size;
  modport source (output valid, window_size, input ready);
  modport sink   (input valid, window_size, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/windowed_tanimoto_similarity.sv
// Windowed Tanimoto similarity. Loads are taken back to back while idle. A
// compute request holds the request channel until the score is registered:
// an exact-match merge, then, for each A key not already matched,
// nearest-neighbor scans through the one read port of each key memory, then
// the 42-bit serial divide, one quotient bit per cycle. Each key memory word
// holds a match mark beside the key; a load writes it clear. A pending result
// does not block new loads. Depends on wts_pkg, wts_if and wts_div.
`default_nettype none
module windowed_tanimoto_similarity import wts_pkg::*; #(
  parameter int unsigned MAX_KEYS = 256
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wts_req_if.sink   req_i,
  wts_res_if.source res_o,
  wts_cfg_if.sink   cfg_i
);
  localparam int unsigned AW   = $clog2(MAX_KEYS);
  localparam int unsigned CW   = AW + 1;
  localparam int unsigned NumW = CW + 16;
  localparam int unsigned DenW = CW + 17;
  localparam int unsigned DvdW = NumW + 17;

  state_e state_q;

  logic [KeyW:0]   mem_a [MAX_KEYS];
  logic [KeyW:0]   mem_b [MAX_KEYS];
  logic [KeyW:0]   a_rd_q, b_rd_q, a_wdata, b_wdata;
  logic [AW-1:0]   a_raddr, b_raddr, a_waddr, b_waddr;
  logic            a_we, b_we;

  logic [CW-1:0]   cnt_a_q, cnt_b_q, i_q, j_q, sc_q, scan_cnt;
  logic [KeyW-1:0] last_a_q, last_b_q;
  logic            drop_q;
  logic [WinW-1:0] win_q, win_eff;

  logic [NumW-1:0] num_q;
  logic [KeyW-1:0] tgt_q, akey_q, best_q, bkey_q, d1_q, key_dist;
  logic [AW-1:0]   bidx_q, bi_q, pidx_q;
  logic            found_q, pv_q;
  logic            scan_mark, scan_end, mrg_hit, pair_hit;

  logic [SimW-1:0]  sim_q;
  logic [StatW-1:0] stat_q;
  logic             out_v_q;
  logic [SimW-1:0]  res_sim_q;
  logic [StatW-1:0] res_stat_q;

  logic [DenW-1:0] den_full, den;
  logic [DvdW-1:0] dvd;
  logic            div_start, div_done;
  logic [DvdW-1:0] quot;
  logic            req_fire, load_ok_a, load_ok_b;

  assign win_eff  = (win_q > MAX_WIN) ? MAX_WIN : win_q;
  assign req_fire = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign load_ok_a = (cnt_a_q != CW'(MAX_KEYS)) &&
                     ((cnt_a_q == '0) || (req_i.key > last_a_q));
  assign load_ok_b = (cnt_b_q != CW'(MAX_KEYS)) &&
                     ((cnt_b_q == '0) || (req_i.key > last_b_q));

  assign scan_cnt  = (state_q == S_SCAN_B) ? cnt_b_q : cnt_a_q;
  assign scan_mark = (state_q == S_SCAN_B) ? b_rd_q[KeyW] : a_rd_q[KeyW];
  assign scan_end  = !pv_q && (sc_q >= scan_cnt);
  assign mrg_hit   = (state_q == S_MRG_CMP) &&
                     (a_rd_q[KeyW-1:0] == b_rd_q[KeyW-1:0]);
  assign pair_hit  = (state_q == S_SCAN_A) && scan_end && found_q &&
                     (bidx_q == i_q[AW-1:0]) && (best_q == d1_q) &&
                     (d1_q <= KeyW'(win_eff));

  always_comb begin
    a_raddr = i_q[AW-1:0];
    b_raddr = j_q[AW-1:0];
    if (state_q == S_SCAN_A) a_raddr = sc_q[AW-1:0];
    if (state_q == S_SCAN_B) b_raddr = sc_q[AW-1:0];
  end

  always_comb begin
    a_we    = 1'b0;
    a_waddr = cnt_a_q[AW-1:0];
    a_wdata = {1'b0, req_i.key};
    b_we    = 1'b0;
    b_waddr = cnt_b_q[AW-1:0];
    b_wdata = {1'b0, req_i.key};
    if (req_fire && (req_i.req_type == REQ_LOAD_A) && load_ok_a) a_we = 1'b1;
    if (req_fire && (req_i.req_type == REQ_LOAD_B) && load_ok_b) b_we = 1'b1;
    if (mrg_hit) begin
      a_we    = 1'b1;
      a_waddr = i_q[AW-1:0];
      a_wdata = {1'b1, a_rd_q[KeyW-1:0]};
      b_we    = 1'b1;
      b_waddr = j_q[AW-1:0];
      b_wdata = {1'b1, b_rd_q[KeyW-1:0]};
    end
    if (pair_hit) begin
      a_we    = 1'b1;
      a_waddr = i_q[AW-1:0];
      a_wdata = {1'b1, akey_q};
      b_we    = 1'b1;
      b_waddr = bi_q;
      b_wdata = {1'b1, tgt_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_we) mem_a[a_waddr] <= a_wdata;
    a_rd_q <= mem_a[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) mem_b[b_waddr] <= b_wdata;
    b_rd_q <= mem_b[b_raddr];
  end

  assign key_dist = abs_diff((state_q == S_SCAN_B) ? b_rd_q[KeyW-1:0] : a_rd_q[KeyW-1:0],
                             tgt_q);

  assign den_full  = DenW'({1'b0, cnt_a_q} + {1'b0, cnt_b_q}) << 16;
  assign den       = den_full - DenW'(num_q);
  assign dvd       = (DvdW'(num_q) << 16) + DvdW'(den >> 1);
  assign div_start = (state_q == S_DIV_ST) && (DenW'(num_q) < den_full);

  wts_div #(.NW(DvdW), .DW(DenW)) u_div (
    .clk_i, .rst_ni,
    .start_i   (div_start),
    .dividend_i(dvd),
    .divisor_i (den),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      win_q      <= MAX_WIN;
      cnt_a_q    <= '0;
      cnt_b_q    <= '0;
      drop_q     <= 1'b0;
      out_v_q    <= 1'b0;
      i_q        <= '0;
      j_q        <= '0;
      sc_q       <= '0;
      pv_q       <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      if (cfg_i.valid) win_q <= cfg_i.window_size;
      if (out_v_q && res_o.ready) out_v_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            if (req_i.req_type == REQ_LOAD_A) begin
              if (load_ok_a) begin
                cnt_a_q  <= cnt_a_q + 1'b1;
                last_a_q <= req_i.key;
              end else begin
                drop_q <= 1'b1;
              end
            end else if (req_i.req_type == REQ_LOAD_B) begin
              if (load_ok_b) begin
                cnt_b_q  <= cnt_b_q + 1'b1;
                last_b_q <= req_i.key;
              end else begin
                drop_q <= 1'b1;
              end
            end else if (req_i.req_type == REQ_COMPUTE) begin
              num_q    <= '0;
              sim_q    <= '0;
              i_q      <= '0;
              j_q      <= '0;
              if (cnt_a_q == '0 && cnt_b_q == '0) begin
                stat_q  <= STAT_BOTH_EMPT;
                state_q <= S_DONE;
              end else if (cnt_a_q == '0 || cnt_b_q == '0) begin
                stat_q  <= STAT_ONE_EMPT;
                state_q <= S_DONE;
              end else begin
                stat_q  <= drop_q ? STAT_DROPPED : STAT_OK;
                state_q <= S_MRG_RD;
              end
            end
          end
        end
        S_MRG_RD: begin
          if (i_q < cnt_a_q && j_q < cnt_b_q) begin
            state_q <= S_MRG_CMP;
          end else begin
            i_q     <= '0;
            state_q <= S_PA_RD;
          end
        end
        S_MRG_CMP: begin
          if (mrg_hit) begin
            num_q <= num_q + NumW'(Q16_ONE);
            i_q <= i_q + 1'b1;
            j_q <= j_q + 1'b1;
          end else if (a_rd_q[KeyW-1:0] < b_rd_q[KeyW-1:0]) begin
            i_q <= i_q + 1'b1;
          end else begin
            j_q <= j_q + 1'b1;
          end
          state_q <= S_MRG_RD;
        end
        S_PA_RD: begin
          if (i_q >= cnt_a_q) begin
            state_q <= S_DIV_ST;
          end else begin
            state_q <= S_PA_WT;
          end
        end
        S_PA_WT: begin
          if (a_rd_q[KeyW]) begin
            i_q     <= i_q + 1'b1;
            state_q <= S_PA_RD;
          end else begin
            tgt_q   <= a_rd_q[KeyW-1:0];
            akey_q  <= a_rd_q[KeyW-1:0];
            sc_q    <= '0;
            pv_q    <= 1'b0;
            found_q <= 1'b0;
            state_q <= S_SCAN_B;
          end
        end
        S_SCAN_B, S_SCAN_A: begin
          if (sc_q < scan_cnt) begin
            pv_q   <= 1'b1;
            pidx_q <= sc_q[AW-1:0];
            sc_q   <= sc_q + 1'b1;
          end else begin
            pv_q <= 1'b0;
          end
          if (pv_q && !scan_mark && (!found_q || key_dist < best_q)) begin
            found_q <= 1'b1;
            best_q  <= key_dist;
            bidx_q  <= pidx_q;
            bkey_q  <= b_rd_q[KeyW-1:0];
          end
          if (scan_end) begin
            if (state_q == S_SCAN_B) begin
              if (found_q) begin
                d1_q    <= best_q;
                bi_q    <= bidx_q;
                tgt_q   <= bkey_q;
                sc_q    <= '0;
                found_q <= 1'b0;
                state_q <= S_SCAN_A;
              end else begin
                i_q     <= i_q + 1'b1;
                state_q <= S_PA_RD;
              end
            end else begin
              if (pair_hit) begin
                num_q <= num_q + NumW'(weight_q16(d1_q[WinW-1:0]));
              end
              i_q     <= i_q + 1'b1;
              state_q <= S_PA_RD;
            end
          end
        end
        S_DIV_ST: begin
          state_q <= div_start ? S_DIV : S_DONE;
        end
        S_DIV: begin
          if (div_done) begin
            sim_q   <= (quot > DvdW'(Q16_ONE)) ? Q16_ONE : quot[SimW-1:0];
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_v_q) begin
            out_v_q    <= 1'b1;
            res_sim_q  <= sim_q;
            res_stat_q <= stat_q;
            cnt_a_q    <= '0;
            cnt_b_q    <= '0;
            drop_q     <= 1'b0;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o.valid      = out_v_q;
  assign res_o.similarity = res_sim_q;
  assign res_o.status     = res_stat_q;
endmodule
`default_nettype wire

FILE: hw/rtl/wts_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
`default_nettype none
module wts_div #(
  parameter int unsigned NW = 42,
  parameter int unsigned DW = 26
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic               done_o,
  output logic [NW-1:0]      quot_o
);
  localparam int unsigned CntW = $clog2(NW + 1);

  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [NW-1:0]   quo_q;
  logic [DW-1:0]   den_q;
  logic [DW:0]     rem_q;
  logic [DW:0]     trial;
  logic [DW+1:0]   shifted;

  always_comb begin
    shifted = {rem_q, quo_q[NW-1]};
    trial   = shifted[DW:0] - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_q <= trial;
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= shifted[DW:0];
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule
`default_nettype wire

FILE: tb/wts_tb_if.sv
// Free-running testbench clock, 12 ns period.
// No dependencies.
`default_nettype none
module wts_tb_clkgen (
  output logic clk_o
);
  timeunit 1ns;
  timeprecision 1ps;
  initial clk_o = 1'b0;
  always begin
    #6 clk_o = 1'b1;
    #6 clk_o = 1'b0;
  end
endmodule
`default_nettype wire

FILE: tb/windowed_tanimoto_similarity_test.sv
// Testbench for windowed_tanimoto_similarity: directed table, A overfill, then random key
// sets, scored by a local Tanimoto predictor. Depends on wts_pkg, wts_if, wts_tb_clkgen.
`default_nettype none
module windowed_tanimoto_similarity_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wts_pkg::*;

  localparam int Depth = 256;
  localparam int StallLimit = 200000;
  localparam logic [ReqW-1:0] ReqUnused = 2'd3;

  typedef struct packed {
    logic [SimW-1:0]  similarity;
    logic [StatW-1:0] status;
  } score_t;

  typedef struct {
    logic [ReqW-1:0] req;
    logic [KeyW-1:0] key;
    bit              fixed;
    score_t          want;
  } row_t;

  logic clk_i;
  logic rst_ni;
  wts_req_if req_ch ();
  wts_res_if res_ch ();
  wts_cfg_if cfg_ch ();

  wts_tb_clkgen u_clk (.clk_o(clk_i));

  windowed_tanimoto_similarity u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch.sink),
    .res_o (res_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  logic [KeyW-1:0] keys_a[Depth];
  logic [KeyW-1:0] keys_b[Depth];
  bit              mark_a[Depth];
  bit              mark_b[Depth];
  int              cnt_a, cnt_b;
  bit              dropped;
  logic [WinW-1:0] win_reg;
  score_t          pending_scores[$];
  int              errors;
  int              idle_cycles;
  bit              quiet;
  bit              fixed_queue[$];
  score_t          fixed_want[$];

  function automatic logic [63:0] qweight(int d);
    case (d)
      0: return 64'd65536;
      1: return 64'd65130;
      2: return 64'd64042;
      3: return 64'd61158;
      4: return 64'd55135;
      default: return 64'd45318;
    endcase
  endfunction

  function automatic logic [KeyW-1:0] key_dist(logic [KeyW-1:0] x, logic [KeyW-1:0] y);
    return (x > y) ? x - y : y - x;
  endfunction

  function automatic int nearest_free(bit use_b, logic [KeyW-1:0] v, output logic [KeyW-1:0] d);
    int bi;
    logic [KeyW-1:0] kd;
    int n;
    bi = -1;
    d = '0;
    n = use_b ? cnt_b : cnt_a;
    for (int i = 0; i < n; i++) begin
      if (use_b ? mark_b[i] : mark_a[i]) continue;
      kd = key_dist(use_b ? keys_b[i] : keys_a[i], v);
      if (bi < 0 || kd < d) begin
        bi = i;
        d = kd;
      end
    end
    return bi;
  endfunction

  function automatic logic [SimW-1:0] tanimoto();
    logic [63:0] num, den, q;
    logic [KeyW-1:0] d1, d2;
    int i, j, bi, ai, w;
    w = int'((win_reg > MAX_WIN) ? MAX_WIN : win_reg);
    num = 0;
    for (int k = 0; k < Depth; k++) begin
      mark_a[k] = 1'b0;
      mark_b[k] = 1'b0;
    end
    i = 0;
    j = 0;
    while (i < cnt_a && j < cnt_b) begin
      if (keys_a[i] == keys_b[j]) begin
        num += 65536;
        mark_a[i] = 1'b1;
        mark_b[j] = 1'b1;
        i++;
        j++;
      end else if (keys_a[i] < keys_b[j]) i++;
      else j++;
    end
    for (i = 0; i < cnt_a; i++) begin
      if (mark_a[i]) continue;
      bi = nearest_free(1'b1, keys_a[i], d1);
      if (bi < 0) continue;
      ai = nearest_free(1'b0, keys_b[bi], d2);
      if (ai != i || d1 != d2) continue;
      if (d1 <= w) begin
        num += qweight(d1);
        mark_a[i] = 1'b1;
        mark_b[bi] = 1'b1;
      end
    end
    den = (cnt_a + cnt_b) * 64'd65536;
    if (num >= den) return '0;
    den -= num;
    q = (num * 64'd65536 + den / 2) / den;
    if (q > 65536) q = 65536;
    return q[SimW-1:0];
  endfunction

  function automatic void load_key(bit to_b, logic [KeyW-1:0] k);
    int n;
    n = to_b ? cnt_b : cnt_a;
    if (n >= Depth || (n > 0 && k <= (to_b ? keys_b[n-1] : keys_a[n-1]))) begin
      dropped = 1'b1;
      return;
    end
    if (to_b) begin
      keys_b[n] = k;
      cnt_b++;
    end else begin
      keys_a[n] = k;
      cnt_a++;
    end
  endfunction

  function automatic void predict_request(logic [ReqW-1:0] req, logic [KeyW-1:0] k);
    score_t s;
    if (req == REQ_LOAD_A) load_key(1'b0, k);
    else if (req == REQ_LOAD_B) load_key(1'b1, k);
    else if (req == REQ_COMPUTE) begin
      s.similarity = '0;
      if (cnt_a == 0 && cnt_b == 0) s.status = STAT_BOTH_EMPT;
      else if (cnt_a == 0 || cnt_b == 0) s.status = STAT_ONE_EMPT;
      else begin
        s.similarity = tanimoto();
        s.status = dropped ? STAT_DROPPED : STAT_OK;
      end
      cnt_a = 0;
      cnt_b = 0;
      dropped = 1'b0;
      pending_scores.push_back(s);
    end
  endfunction

  task automatic idle_burst();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  task automatic send(logic [ReqW-1:0] req, logic [KeyW-1:0] k, bit fixed, score_t want);
    idle_burst();
    req_ch.valid <= 1'b1;
    req_ch.req_type <= req;
    req_ch.key <= k;
    do @(posedge clk_i); while (!req_ch.ready);
    predict_request(req, k);
    if (req == REQ_COMPUTE) begin
      fixed_queue.push_back(fixed);
      fixed_want.push_back(want);
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_window(logic [WinW-1:0] w);
    cfg_ch.valid <= 1'b1;
    cfg_ch.window_size <= w;
    do @(posedge clk_i); while (!cfg_ch.ready);
    win_reg = w;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_set(int max_n, int spread);
    int na, nb;
    logic [KeyW-1:0] base, ka, kb;
    na = $urandom_range(0, max_n);
    nb = $urandom_range(0, max_n);
    base = $urandom;
    ka = base;
    kb = base + $urandom_range(0, spread);
    for (int i = 0; i < na + nb; i++) begin
      if ($urandom_range(0, 30) == 0) begin
        send(ReqW'($urandom_range(0, 1)), $urandom, 1'b0, '0);
      end else if ($urandom_range(0, 40) == 0) begin
        send(ReqUnused, $urandom, 1'b0, '0);
      end else if ((i < na && $urandom_range(0, 1)) || i >= na + nb - 1 && i < na) begin
        ka = ka + $urandom_range(1, spread);
        send(REQ_LOAD_A, ka, 1'b0, '0);
      end else begin
        kb = kb + $urandom_range(1, spread);
        send(REQ_LOAD_B, kb, 1'b0, '0);
      end
    end
    send(REQ_COMPUTE, $urandom, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_ch.valid || res_ch.valid && res_ch.ready || cfg_ch.valid) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
      end else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("windowed_tanimoto_similarity_test NOT OK");
        $finish;
      end
      if (res_ch.valid && res_ch.ready) begin
        if (pending_scores.size() == 0) begin
          $error("unexpected result similarity %0d status %0d", res_ch.similarity,
                 res_ch.status);
          errors++;
        end else begin
          score_t w;
          w = pending_scores.pop_front();
          if (fixed_queue.pop_front()) begin
            score_t f;
            f = fixed_want.pop_front();
            if (f != w) begin
              $error("table row disagrees: similarity exp %0d got %0d", f.similarity,
                     w.similarity);
              errors++;
            end
          end else void'(fixed_want.pop_front());
          if (res_ch.similarity !== w.similarity) begin
            $error("similarity exp %0d got %0d", w.similarity, res_ch.similarity);
            errors++;
          end
          if (res_ch.status !== w.status) begin
            $error("status exp %0d got %0d", w.status, res_ch.status);
            errors++;
          end
        end
      end
      if (!quiet && $urandom_range(0, 6) == 0) res_ch.ready <= 1'b0;
      else if (quiet || $urandom_range(0, 3) == 0) res_ch.ready <= 1'b1;
    end
  end

  row_t tbl[$];

  function automatic row_t mk(logic [ReqW-1:0] r, logic [KeyW-1:0] k, bit f,
                              logic [SimW-1:0] s, logic [StatW-1:0] st);
    row_t x;
    x.req = r;
    x.key = k;
    x.fixed = f;
    x.want.similarity = s;
    x.want.status = st;
    return x;
  endfunction

  initial begin
    errors = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    cnt_a = 0;
    cnt_b = 0;
    dropped = 1'b0;
    win_reg = MAX_WIN;
    rst_ni = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_LOAD_A;
    req_ch.key = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.window_size = MAX_WIN;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    tbl.push_back(mk(REQ_COMPUTE, 32'h0, 1'b1, '0, STAT_BOTH_EMPT));
    tbl.push_back(mk(REQ_LOAD_A, 32'h0, 1'b0, '0, '0));
    tbl.push_back(mk(REQ_COMPUTE, 32'h0, 1'b1, '0, STAT_ONE_EMPT));
    tbl.push_back(mk(REQ_LOAD_A, 32'h0, 1'b0, '0, '0));
    tbl.push_back(mk(REQ_LOAD_A, 32'hffffffff, 1'b0, '0, '0));
    tbl.push_back(mk(REQ_LOAD_B, 32'h0, 1'b0, '0, '0));
    tbl.push_back(mk(REQ_LOAD_B, 32'hffffffff, 1'b0, '0, '0));
    tbl.push_back(mk(REQ_COMPUTE, 32'hffffffff, 1'b1, 17'd65536, STAT_OK));
    tbl.push_back(mk(REQ_LOAD_A, 32'd100, 1'b0, '0, '0));
    tbl.push_back(mk(REQ_LOAD_A, 32'd100, 1'b0, '0, '0));
    tbl.push_back(mk(REQ_LOAD_B, 32'd103, 1'b0, '0, '0));
    tbl.push_back(mk(ReqUnused, 32'haaaaaaaa, 1'b0, '0, '0));
    tbl.push_back(mk(REQ_COMPUTE, 32'h0, 1'b0, '0, '0));
    tbl.push_back(mk(REQ_LOAD_B, 32'd7, 1'b0, '0, '0));
    tbl.push_back(mk(REQ_COMPUTE, 32'h0, 1'b1, '0, STAT_ONE_EMPT));
    tbl.push_back(mk(REQ_LOAD_A, 32'd10, 1'b0, '0, '0));
    tbl.push_back(mk(REQ_LOAD_A, 32'd14, 1'b0, '0, '0));
    tbl.push_back(mk(REQ_LOAD_A, 32'd30, 1'b0, '0, '0));
    tbl.push_back(mk(REQ_LOAD_B, 32'd12, 1'b0, '0, '0));
    tbl.push_back(mk(REQ_LOAD_B, 32'd35, 1'b0, '0, '0));
    tbl.push_back(mk(REQ_COMPUTE, 32'h0, 1'b0, '0, '0));
    foreach (tbl[i]) send(tbl[i].req, tbl[i].key, tbl[i].fixed, tbl[i].want);
    drain();

    for (int i = 0; i < Depth + 2; i++) send(REQ_LOAD_A, i * 3, 1'b0, '0);
    for (int i = 0; i < 4; i++) send(REQ_LOAD_B, i * 5 + 1, 1'b0, '0);
    send(REQ_COMPUTE, '0, 1'b0, '0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_window(WinW'(ph == 0 ? 0 : ph == 1 ? 7 : ph == 2 ? 6 : $urandom_range(0, 7)));
      for (int s = 0; s < 12; s++) random_set(6, ph[0] ? 3 : 8);
      if (ph == 3) drain();
      if (ph == 6) quiet = 1'b1;
      drain();
    end
    send(REQ_LOAD_A, $urandom, 1'b0, '0);
    send(REQ_LOAD_B, $urandom, 1'b0, '0);
    send(REQ_COMPUTE, '0, 1'b0, '0);
    drain();

    if (errors == 0) begin
      $display("windowed_tanimoto_similarity_test OK");
    end else begin
      $display("windowed_tanimoto_similarity_test NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
